// File: design/entry_map_lookup_or_insert_core_defines.svh
// ----------------------------------------------------------------------------
// entry map lookup-or-insert core: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ENTRY_MAP_LOOKUP_OR_INSERT_CORE_DEFINES_SVH
`define ENTRY_MAP_LOOKUP_OR_INSERT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define EMLI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("emli check failed");

// next-cycle implication, checked out of reset
`define EMLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("emli check failed");

`endif

// File: design/emli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emli_pkg
// Types, codes and constants shared by the entry map lookup-or-insert core.
// ----------------------------------------------------------------------------
package emli_pkg;

   // table geometry and field widths
   localparam int SLOTS_DEFAULT = 512;
   localparam int KEY_W         = 32;
   localparam int HANDLE_W      = 11;
   localparam int OFFSET_W      = 10;
   localparam int OPCODE_W      = 2;
   localparam int STATUS_W      = 2;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(3);

   // request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_FIND_OR_ADD = 2'd0,
      OP_GET         = 2'd1,
      OP_SET         = 2'd2,
      OP_CLEAR       = 2'd3
   } opcode_type;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // memory read source
   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_SCAN = 2'd1,
      RD_SLOT = 2'd2
   } rd_sel_type;

   // memory write source
   typedef enum logic [2:0] {
      WR_NONE   = 3'd0,
      WR_SWEEP  = 3'd1,
      WR_SET    = 3'd2,
      WR_ZERO   = 3'd3,
      WR_INSERT = 3'd4
   } wr_sel_type;

   // which response the datapath builds
   typedef enum logic [2:0] {
      RK_NONE   = 3'd0,
      RK_HIT    = 3'd1,
      RK_INSERT = 3'd2,
      RK_FULL   = 3'd3,
      RK_RANGE  = 3'd4,
      RK_READ   = 3'd5
   } rsp_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      logic         respond;
      rsp_kind_type rsp_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      opcode_type opcode;
      logic       range_err;
      logic       scan_hit;
      logic       scan_last;
      logic       sweep_last;
      logic       have_empty;
   } sts_type;

endpackage

// File: design/emli_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emli_ctrl
// Sequencer for the lookup-or-insert core: clearing sweep, request decode,
// slot scan and response timing.
// ----------------------------------------------------------------------------
module emli_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [emli_pkg::OPCODE_W-1:0]        req_opcode,
   output logic                                 busy,
   output emli_pkg::cmd_type                    cmd,
   input  emli_pkg::sts_type                    sts
);
   import emli_pkg::*;

   typedef enum logic [5:0] {
      S_SWEEP  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_FINISH = 6'b001000,
      S_ACCESS = 6'b010000,
      S_RDWAIT = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.rd_sel   = RD_NONE;
      cmd.wr_sel   = WR_NONE;
      cmd.respond  = 1'b0;
      cmd.rsp_kind = RK_NONE;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.wr_sel = WR_SWEEP;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (opcode_type'(req_opcode) == OP_FIND_OR_ADD) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_ACCESS;
               end
            end
         end
         S_SCAN: begin
            cmd.rd_sel = RD_SCAN;
            priority if (sts.scan_hit) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RK_HIT;
               state_in     = S_IDLE;
            end else if (sts.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
            if (sts.have_empty) begin
               cmd.wr_sel   = WR_INSERT;
               cmd.rsp_kind = RK_INSERT;
            end else begin
               cmd.rsp_kind = RK_FULL;
            end
         end
         S_ACCESS: begin
            if (sts.range_err) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RK_RANGE;
               state_in     = S_IDLE;
            end else begin
               unique case (sts.opcode)
                  OP_GET: begin
                     cmd.rd_sel = RD_SLOT;
                     state_in   = S_RDWAIT;
                  end
                  OP_SET: begin
                     cmd.wr_sel  = WR_SET;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end
                  OP_CLEAR: begin
                     cmd.wr_sel  = WR_ZERO;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end
                  default: begin
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            cmd.respond  = 1'b1;
            cmd.rsp_kind = RK_READ;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_SWEEP;
         end
      endcase
   end

endmodule

// File: design/emli_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emli_dpath
// Slot memory with registered read, scan pointer, compare stage, handle range
// check, offset register and response registers.
// ----------------------------------------------------------------------------
module emli_dpath #(
   parameter int SLOTS = emli_pkg::SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [emli_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [emli_pkg::KEY_W-1:0]           req_key,
   input  logic [emli_pkg::HANDLE_W-1:0]        req_handle,
   input  logic                                 csr_valid,
   input  logic [emli_pkg::OFFSET_W-1:0]        csr_data,
   input  emli_pkg::cmd_type                    cmd,
   output emli_pkg::sts_type                    sts,
   output logic                                 rsp_valid,
   output logic [emli_pkg::HANDLE_W-1:0]        rsp_result_handle,
   output logic [emli_pkg::KEY_W-1:0]           rsp_read_value,
   output logic [emli_pkg::STATUS_W-1:0]        rsp_status
);
   import emli_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam logic [SW-1:0]       LAST_SLOT   = SW'(SLOTS - 1);
   localparam logic [HANDLE_W-1:0] SLOTS_WIDE  = HANDLE_W'(SLOTS);

   // slot memory and read register
   logic [KEY_W-1:0]    mem [SLOTS];
   logic [KEY_W-1:0]    rd_data_ff;

   // captured request
   opcode_type          op_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [HANDLE_W-1:0] handle_ff;

   // config register
   logic [OFFSET_W-1:0] offset_ff;

   // scan state
   logic [SW-1:0]       idx_ff;
   logic [SW-1:0]       idx_in;
   logic                cmp_valid_ff;
   logic [SW-1:0]       cmp_idx_ff;
   logic                have_empty_ff;
   logic [SW-1:0]       empty_ff;

   // response registers
   logic                rsp_valid_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [KEY_W-1:0]    rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_in;
   logic [KEY_W-1:0]    rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_in;

   // derived signals
   logic                advance;
   logic                cmp_match;
   logic                cmp_empty;
   logic [HANDLE_W-1:0] rel_handle;
   logic                range_err;
   logic [SW-1:0]       target_slot;
   logic                mem_we;
   logic [SW-1:0]       mem_waddr;
   logic [KEY_W-1:0]    mem_wdata;
   logic                mem_re;
   logic [SW-1:0]       mem_raddr;

   // handle to slot translation
   assign rel_handle  = handle_ff - HANDLE_W'(offset_ff);
   assign range_err   = (handle_ff < HANDLE_W'(offset_ff)) || (rel_handle >= SLOTS_WIDE);
   assign target_slot = rel_handle[SW-1:0];

   // compare stage on the slot read last cycle
   assign cmp_match = cmp_valid_ff && (rd_data_ff == key_ff);
   assign cmp_empty = cmp_valid_ff && (rd_data_ff == '0);

   // pointer walks the table during the sweep and the scan
   assign advance = (cmd.wr_sel == WR_SWEEP) || (cmd.rd_sel == RD_SCAN);
   assign idx_in  = (idx_ff == LAST_SLOT) ? '0 : idx_ff + SW'(1);

   // write port select
   always_comb begin
      mem_we    = 1'b1;
      mem_waddr = target_slot;
      mem_wdata = '0;
      unique case (cmd.wr_sel)
         WR_SWEEP:  mem_waddr = idx_ff;
         WR_SET:    mem_wdata = key_ff;
         WR_ZERO:   mem_wdata = '0;
         WR_INSERT: begin
            mem_waddr = empty_ff;
            mem_wdata = key_ff;
         end
         default:   mem_we = 1'b0;
      endcase
   end

   // read port select
   assign mem_re    = (cmd.rd_sel == RD_SCAN) || (cmd.rd_sel == RD_SLOT);
   assign mem_raddr = (cmd.rd_sel == RD_SCAN) ? idx_ff : target_slot;

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= opcode_type'(req_opcode);
         key_ff    <= req_key;
         handle_ff <= req_handle;
      end
   end

   // offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_valid) begin
         offset_ff <= csr_data;
      end
   end

   // scan pointer and first-empty tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         cmp_valid_ff  <= 1'b0;
         have_empty_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (advance) begin
            idx_ff <= idx_in;
         end
         cmp_valid_ff <= !cmd.load && (cmd.rd_sel == RD_SCAN);
         if (cmd.load) begin
            have_empty_ff <= 1'b0;
         end else if (cmp_empty && !have_empty_ff) begin
            have_empty_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_sel == RD_SCAN) begin
         cmp_idx_ff <= idx_ff;
      end
      if (cmp_empty && !have_empty_ff) begin
         empty_ff <= cmp_idx_ff;
      end
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   // response payload select
   always_comb begin
      rsp_handle_in = '0;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      unique case (cmd.rsp_kind)
         RK_HIT:    rsp_handle_in = HANDLE_W'(cmp_idx_ff) + HANDLE_W'(offset_ff);
         RK_INSERT: rsp_handle_in = HANDLE_W'(empty_ff) + HANDLE_W'(offset_ff);
         RK_FULL:   rsp_status_in = ST_FULL;
         RK_RANGE:  rsp_status_in = ST_RANGE;
         RK_READ:   rsp_value_in  = rd_data_ff;
         default:   rsp_status_in = ST_OK;
      endcase
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_handle_ff <= rsp_handle_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // status to the controller
   assign sts.opcode     = op_ff;
   assign sts.range_err  = range_err;
   assign sts.scan_hit   = cmp_match;
   assign sts.scan_last  = cmp_valid_ff && (cmp_idx_ff == LAST_SLOT);
   assign sts.sweep_last = (idx_ff == LAST_SLOT);
   assign sts.have_empty = have_empty_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// File: design/entry_map_lookup_or_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entry_map_lookup_or_insert_core
// Table of SLOTS 32-bit keys addressed by handles (slot index plus a
// programmable offset), with find-or-add, get, set and clear requests.
// ----------------------------------------------------------------------------
// After reset the core sweeps zero through every slot, one per cycle, and
// holds busy high through the sweep; offset writes are taken at any time. A
// request is taken when start is high and busy is low, and its response
// appears for one cycle on rsp_valid, in the first cycle busy is low again.
// Find-or-add walks the slots in order through the single read port of the
// slot memory, one slot per cycle; a match answers from the scan state, an
// insert or a full table from the finish state. Get answers from the read
// wait state; set, clear and an out-of-range handle from the access state.
// The receiver cannot stall the response, and csr_ready is always high; the
// offset should change only while no request is in flight.
module entry_map_lookup_or_insert_core #(
   parameter int SLOTS = emli_pkg::SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [emli_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [emli_pkg::KEY_W-1:0]           req_key,
   input  logic [emli_pkg::HANDLE_W-1:0]        req_handle,
   output logic                                 rsp_valid,
   output logic [emli_pkg::HANDLE_W-1:0]        rsp_result_handle,
   output logic [emli_pkg::KEY_W-1:0]           rsp_read_value,
   output logic [emli_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [emli_pkg::OFFSET_W-1:0]        csr_data
);
   import emli_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   emli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .cmd        (cmd),
      .sts        (sts)
   );

   // table and response datapath
   emli_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_key           (req_key),
      .req_handle        (req_handle),
      .csr_valid         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_result_handle (rsp_result_handle),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status)
   );

endmodule

// File: design/emli_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emli_checker
// Port-level checks on the lookup-or-insert core, bound to the top level.
// ----------------------------------------------------------------------------
`include "entry_map_lookup_or_insert_core_defines.svh"

module emli_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic [emli_pkg::HANDLE_W-1:0]         rsp_result_handle,
   input logic [emli_pkg::KEY_W-1:0]            rsp_read_value,
   input logic [emli_pkg::STATUS_W-1:0]         rsp_status
);
   import emli_pkg::*;

   // a taken request keeps the core busy until its response
   `EMLI_ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy)

   // a response lands as the core goes idle
   `EMLI_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)

   // one response per request, never two in a row
   `EMLI_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

   // idle with no request gives no response
   `EMLI_ASSERT_NEXT(a_no_spurious, clock, reset, !busy && !start, !rsp_valid)

   // failed requests carry zero payload
   `EMLI_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_OK),
      (rsp_result_handle == '0) && (rsp_read_value == '0))

endmodule

bind entry_map_lookup_or_insert_core emli_checker u_emli_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_result_handle (rsp_result_handle),
   .rsp_read_value    (rsp_read_value),
   .rsp_status        (rsp_status)
);

// File: bench/entry_map_lookup_or_insert_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entry_map_lookup_or_insert_core_tb
// Drives find-or-add, get, set and clear requests and handle offset writes
// into the entry map core. A shadow copy of the slot table predicts every
// response, and each response is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module entry_map_lookup_or_insert_core_tb;
   import emli_pkg::*;

   localparam int SLOTS         = SLOTS_DEFAULT;
   localparam int QUIET_LIMIT   = 8 * (SLOTS + 16);
   localparam int SETTLE_CYCLES = SLOTS + 4;
   localparam int SHOWN_LIMIT   = 10;

   // what the request plan can ask of the driver
   typedef enum logic [1:0] {
      ACT_REQUEST = 2'd0,
      ACT_OFFSET  = 2'd1,
      ACT_DRAIN   = 2'd2
   } plan_kind_type;

   typedef struct {
      plan_kind_type       kind;
      opcode_type          opcode;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic [OFFSET_W-1:0] offset;
      int                  gap;
   } plan_step_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    value;
      logic [STATUS_W-1:0] status;
   } table_rsp_type;

   // block ports
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                start      = 1'b0;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [KEY_W-1:0]    req_key    = '0;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic                rsp_valid;
   logic [HANDLE_W-1:0] rsp_result_handle;
   logic [KEY_W-1:0]    rsp_read_value;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [OFFSET_W-1:0] csr_data   = '0;

   // request plan and driver state
   plan_step_type       request_plan [$];
   int                  planned_cnt = 0;
   bit                  no_idle     = 1'b0;
   int                  plan_offset;
   logic [KEY_W-1:0]    key_pool [16];
   int                  gap_left    = 0;
   logic                gap_armed   = 1'b0;
   logic                plan_done   = 1'b0;

   // shadow table and response bookkeeping
   logic [KEY_W-1:0]    shadow_keys [SLOTS];
   logic [OFFSET_W-1:0] shadow_offset = OFFSET_RESET;
   table_rsp_type       table_rsp_due [$];
   int                  due_cnt      = 0;
   int                  mismatch_cnt = 0;
   int                  quiet_cycles = 0;

   entry_map_lookup_or_insert_core #(
      .SLOTS(SLOTS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_key           (req_key),
      .req_handle        (req_handle),
      .rsp_valid         (rsp_valid),
      .rsp_result_handle (rsp_result_handle),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // shadow table: work out the response and apply the table update
   function automatic table_rsp_type predict_table_response(opcode_type op,
                                                            logic [KEY_W-1:0] key,
                                                            logic [HANDLE_W-1:0] handle);
      table_rsp_type rsp;
      int            hit;
      int            empty;
      int            slot;
      rsp   = '0;
      hit   = -1;
      empty = -1;
      slot  = int'(handle) - int'(shadow_offset);
      rsp.status = ST_OK;
      if (op == OP_FIND_OR_ADD) begin
         // first match wins; remember the first empty slot before it
         for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && shadow_keys[i] == key)
               hit = i;
            if (hit < 0 && empty < 0 && shadow_keys[i] == '0)
               empty = i;
         end
         if (hit >= 0) begin
            rsp.handle = HANDLE_W'(hit + int'(shadow_offset));
         end else if (empty >= 0) begin
            shadow_keys[empty] = key;
            rsp.handle = HANDLE_W'(empty + int'(shadow_offset));
         end else begin
            rsp.status = ST_FULL;
         end
      end else if (slot < 0 || slot >= SLOTS) begin
         rsp.status = ST_RANGE;
      end else if (op == OP_GET) begin
         rsp.value = shadow_keys[slot];
      end else if (op == OP_SET) begin
         shadow_keys[slot] = key;
      end else begin
         shadow_keys[slot] = '0;
      end
      return rsp;
   endfunction

   // plan building
   task automatic add_request(opcode_type op, logic [KEY_W-1:0] key,
                              logic [HANDLE_W-1:0] handle);
      plan_step_type step;
      step.kind   = ACT_REQUEST;
      step.opcode = op;
      step.key    = key;
      step.handle = handle;
      step.offset = '0;
      step.gap    = 0;
      // idle bursts, with every third stretch of requests left dense
      if (!no_idle && ((planned_cnt / 48) % 3 != 2) && $urandom_range(0, 3) == 0)
         step.gap = $urandom_range(1, 9);
      planned_cnt++;
      request_plan.push_back(step);
   endtask

   task automatic add_drain();
      plan_step_type step;
      step = '{kind: ACT_DRAIN, opcode: OP_GET, key: '0, handle: '0, offset: '0, gap: 0};
      request_plan.push_back(step);
   endtask

   task automatic add_offset_write(logic [OFFSET_W-1:0] value);
      plan_step_type step;
      step = '{kind: ACT_OFFSET, opcode: OP_GET, key: '0, handle: '0, offset: value, gap: 0};
      add_drain();
      request_plan.push_back(step);
      plan_offset = value;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, 15)];
         6:                return '0;
         default:          return $urandom();
      endcase
   endfunction

   // mostly low slots so gets and clears meet filled entries
   function automatic logic [HANDLE_W-1:0] pick_handle();
      int h;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: h = plan_offset + $urandom_range(0, 23);
         6:                h = plan_offset + $urandom_range(0, SLOTS - 1);
         7: begin
            case ($urandom_range(0, 3))
               0:       h = plan_offset - 1;
               1:       h = plan_offset;
               2:       h = plan_offset + SLOTS - 1;
               default: h = plan_offset + SLOTS;
            endcase
         end
         default:          h = $urandom_range(0, 2047);
      endcase
      return HANDLE_W'(h);
   endfunction

   task automatic add_random_requests(int count);
      for (int i = 0; i < count; i++) begin
         add_request(opcode_type'($urandom_range(0, 3)), pick_key(), pick_handle());
         if ($urandom_range(0, 79) == 0)
            add_drain();
      end
   endtask

   // stimulus plan and end of run
   initial begin
      logic [KEY_W-1:0] last_key;
      logic [KEY_W-1:0] fresh_key;
      int               hole;
      key_pool[0] = 32'hFFFF_FFFF;
      key_pool[1] = 32'h0000_0001;
      for (int i = 2; i < 16; i++)
         key_pool[i] = $urandom_range(32'hFFFF_FFFF, 1);
      plan_offset = OFFSET_RESET;

      // directed: empty table at the reset offset
      add_request(OP_GET, 32'h1234_5678, 11'd3);
      add_request(OP_GET, '0, 11'd2);
      add_request(OP_GET, '0, 11'd514);
      add_request(OP_GET, '0, 11'd515);
      add_request(OP_FIND_OR_ADD, 32'h0000_0000, '0);
      add_request(OP_FIND_OR_ADD, 32'hFFFF_FFFF, 11'h7FF);
      add_request(OP_FIND_OR_ADD, 32'h0000_0001, '0);
      add_request(OP_FIND_OR_ADD, 32'hFFFF_FFFF, '0);
      add_request(OP_CLEAR, 32'hFFFF_FFFF, 11'd3);
      // key present beats the now empty slot in front of it
      add_request(OP_FIND_OR_ADD, 32'h0000_0001, '0);
      add_request(OP_FIND_OR_ADD, 32'h0000_0000, '0);
      add_request(OP_FIND_OR_ADD, 32'h8000_0000, '0);
      // set with zero empties the slot
      add_request(OP_SET, 32'h0000_0000, 11'd4);
      add_request(OP_GET, '0, 11'd4);
      add_request(OP_FIND_OR_ADD, 32'h0000_0000, '0);
      add_request(OP_SET, 32'hA5A5_A5A5, 11'd514);
      add_request(OP_GET, '0, 11'd514);
      add_request(OP_SET, 32'h5A5A_5A5A, 11'h7FF);
      add_request(OP_CLEAR, '0, 11'd0);
      add_request(OP_GET, '0, 11'h7FF);
      add_request(OP_FIND_OR_ADD, 32'h7FFF_FFFE, '0);
      add_request(OP_GET, '0, 11'd3);

      // random mixes at the lowest and at a random offset
      add_offset_write('0);
      add_random_requests(240);
      add_offset_write(OFFSET_W'($urandom_range(1, 1022)));
      add_random_requests(240);

      // highest offset: fill every slot, then work a full table
      add_offset_write(OFFSET_W'(1023));
      last_key = $urandom_range(32'hFFFF_FFFF, 1);
      for (int i = 0; i < SLOTS - 1; i++)
         add_request(OP_SET, (i < 16) ? key_pool[i] : $urandom_range(32'hFFFF_FFFF, 1),
                     HANDLE_W'(plan_offset + i));
      add_request(OP_SET, last_key, HANDLE_W'(plan_offset + SLOTS - 1));
      add_request(OP_FIND_OR_ADD, $urandom_range(32'hFFFF_FFFF, 1), '0);
      add_request(OP_FIND_OR_ADD, 32'h0000_0000, '0);
      add_request(OP_FIND_OR_ADD, last_key, '0);
      add_request(OP_GET, '0, HANDLE_W'(plan_offset + SLOTS - 1));
      add_request(OP_GET, '0, HANDLE_W'(plan_offset + SLOTS));
      add_request(OP_GET, '0, HANDLE_W'(plan_offset - 1));
      hole      = $urandom_range(0, SLOTS - 2);
      fresh_key = $urandom_range(32'hFFFF_FFFF, 1);
      add_request(OP_CLEAR, '0, HANDLE_W'(plan_offset + hole));
      add_request(OP_FIND_OR_ADD, fresh_key, '0);
      add_request(OP_FIND_OR_ADD, fresh_key, '0);

      // dense tail on a nearly full table
      no_idle = 1'b1;
      add_random_requests(150);

      while (!plan_done)
         @(posedge clock);
      while (due_cnt != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && due_cnt == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // driver: one plan step at a time, each output assigned once per edge
   always @(posedge clock) begin
      plan_step_type step;
      logic          start_nxt;
      logic          csr_valid_nxt;
      logic          armed_nxt;
      int            gap_nxt;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
         gap_left  <= 0;
         gap_armed <= 1'b0;
         plan_done <= 1'b0;
      end else begin
         start_nxt     = start && busy;
         csr_valid_nxt = csr_valid && !csr_ready;
         gap_nxt       = gap_left;
         armed_nxt     = gap_armed;
         if (!start_nxt && !csr_valid_nxt && request_plan.size() != 0) begin
            step = request_plan[0];
            case (step.kind)
               ACT_REQUEST: begin
                  if (!armed_nxt) begin
                     gap_nxt   = step.gap;
                     armed_nxt = 1'b1;
                  end
                  if (gap_nxt != 0) begin
                     gap_nxt--;
                  end else begin
                     req_opcode <= step.opcode;
                     req_key    <= step.key;
                     req_handle <= step.handle;
                     start_nxt  = 1'b1;
                     armed_nxt  = 1'b0;
                     void'(request_plan.pop_front());
                  end
               end
               ACT_OFFSET: begin
                  csr_data      <= step.offset;
                  csr_valid_nxt = 1'b1;
                  void'(request_plan.pop_front());
               end
               default: begin
                  // hold off until every owed response has come back
                  if (!start && !csr_valid && due_cnt == 0)
                     void'(request_plan.pop_front());
               end
            endcase
         end
         start     <= start_nxt;
         csr_valid <= csr_valid_nxt;
         gap_left  <= gap_nxt;
         gap_armed <= armed_nxt;
         plan_done <= request_plan.size() == 0 && !start_nxt && !csr_valid_nxt;
      end
   end

   // monitor: predict on each accepted request, check each response
   always @(posedge clock) begin
      table_rsp_type want;
      table_rsp_type got;
      logic          moved;
      if (reset) begin
         foreach (shadow_keys[i])
            shadow_keys[i] = '0;
         shadow_offset = OFFSET_RESET;
         quiet_cycles  = 0;
         due_cnt      <= 0;
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            shadow_offset = csr_data;
            moved         = 1'b1;
         end
         if (start && !busy) begin
            table_rsp_due.push_back(predict_table_response(opcode_type'(req_opcode),
                                                           req_key, req_handle));
            moved = 1'b1;
         end
         if (rsp_valid) begin
            moved = 1'b1;
            got   = '{rsp_result_handle, rsp_read_value, rsp_status};
            if (table_rsp_due.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= SHOWN_LIMIT)
                  $display("unexpected response: handle %0d value %h status %0d",
                           got.handle, got.value, got.status);
            end else begin
               want = table_rsp_due.pop_front();
               if (got.handle !== want.handle || got.value !== want.value ||
                   got.status !== want.status) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= SHOWN_LIMIT)
                     $display("response mismatch: expected handle %0d value %h status %0d, %s",
                              want.handle, want.value, want.status,
                              $sformatf("got handle %0d value %h status %0d",
                                        got.handle, got.value, got.status));
               end
            end
         end
         due_cnt <= table_rsp_due.size();
         // watchdog on cycles with no handshake at all
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

endmodule
